// ===== sv/itoa_pkg.sv =====
`timescale 1ns / 1ps
// itoa_pkg: shared types, constants and the digit-to-ASCII mapping for the
// radix-to-ASCII converter. No dependencies.
package itoa_pkg;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 6'd35;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;  // '0'
	localparam logic [CHAR_W-1:0]  ASCII_ALPHA = 7'd55;  // 'A' minus ten

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} itoa_state_t;

	// control into and status out of the bit-serial divider
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// digit value to ASCII, '0'..'9' then 'A'..'Z'; out-of-range clamps to 'Z'
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] dc;
		dc = (d > DIGIT_MAX) ? DIGIT_MAX : d;
		if (dc < DIGIT_TEN)
			return ASCII_ZERO + CHAR_W'(dc);
		else
			return ASCII_ALPHA + CHAR_W'(dc);
	endfunction

endpackage

// ===== sv/itoa_ifs.sv =====
`timescale 1ns / 1ps
// itoa_ifs: valid/ready channel interfaces of the converter: value input,
// character output and radix configuration write. Depends on itoa_pkg.
interface itoa_val_if #(parameter int VALUE_WIDTH = 64);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;
	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface itoa_chr_if;
	logic                          valid;
	logic                          ready;
	logic [itoa_pkg::CHAR_W-1:0]   digit_char;
	logic                          last;
	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

interface itoa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [itoa_pkg::RADIX_W-1:0]  radix;
	modport source (output valid, output radix, input ready);
	modport sink   (input valid, input radix, output ready);
endinterface

// ===== sv/itoa_ram.sv =====
`timescale 1ns / 1ps
// itoa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/itoa_div.sv =====
`timescale 1ns / 1ps
// itoa_div: bit-serial restoring divider by a 6-bit radix, one dividend bit
// per cycle, MSB first. Depends on itoa_pkg.
module itoa_div #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  itoa_pkg::div_ctrl_t            ctrl,
	input  logic [VALUE_WIDTH-1:0]         dividend,
	input  logic [itoa_pkg::RADIX_W-1:0]   radix,
	output itoa_pkg::div_stat_t            stat,
	output logic [VALUE_WIDTH-1:0]         quotient,
	output logic [itoa_pkg::DIGIT_W-1:0]   remainder
);
	import itoa_pkg::*;

	localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	logic                   busy_q;
	logic                   done_q;
	logic [CW-1:0]          cnt_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [DIGIT_W-1:0]     rem_q;

	logic [DIGIT_W:0]       partial;
	logic                   fits;
	logic [DIGIT_W:0]       diff;

	// trial subtract of the radix from the shifted partial remainder
	assign partial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign fits    = partial >= {1'b0, radix};
	assign diff    = partial - {1'b0, radix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath: quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (ctrl.start && !busy_q) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== sv/integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps
// integer_to_radix_ascii: top level of the unsigned integer to ASCII converter.
// Depends on itoa_pkg, itoa_ifs, itoa_div and itoa_ram.
//
// Usage
//   din  : one unsigned VALUE_WIDTH-bit value per transaction.
//   dout : one ASCII character per transaction, most significant digit first,
//          last set on the final (least significant) character. Zero gives '0'.
//   cfg  : writes the 6-bit radix (reset 10); 0 and 1 act as 2, 37..63 as 36.
//          Write only while the block is idle; cfg.ready is always high.
// Timing
//   Each digit takes a full pass of the bit-serial divider, which shifts the
//   whole dividend through one bit per cycle. Digits are stored as they are
//   found; once the last is stored, each character passes through a store
//   read and then the output register.
//   din.ready is high only between numbers; a new value may be taken while the
//   final character still waits in the output register.
// Reset and stalls
//   Reset returns to idle with the radix at 10 and no output pending. When the
//   receiver stalls the held character stays in the output register and digit
//   store reads pause until it is taken.
module integer_to_radix_ascii #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	itoa_val_if.sink   din,
	itoa_chr_if.source dout,
	itoa_cfg_if.sink   cfg
);
	import itoa_pkg::*;

	localparam int AW    = $clog2(VALUE_WIDTH);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	itoa_state_t state_q, state_d;

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     radix_eff;
	logic [CNT_W-1:0]       count_q;
	logic [AW-1:0]          rd_ptr_q;
	logic                   rd_pend_q;
	logic                   rd_last_q;
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      digit_char_q;
	logic                   last_q;

	div_ctrl_t              div_ctrl;
	div_stat_t              div_stat;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [VALUE_WIDTH-1:0] div_quo;
	logic [DIGIT_W-1:0]     div_rem;

	logic                   accept;
	logic                   digit_done;
	logic                   finish;
	logic                   out_free;
	logic                   rd_issue;
	logic [DIGIT_W-1:0]     ram_rdata;

	// radix register and clamping
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (cfg.valid && cfg.ready)
			radix_q <= cfg.radix;
	end

	assign radix_eff = (radix_q < RADIX_MIN) ? RADIX_MIN :
	                   (radix_q > RADIX_MAX) ? RADIX_MAX : radix_q;

	// handshake terms
	assign accept     = (state_q == ST_IDLE) && din.valid;
	assign digit_done = (state_q == ST_DIV) && div_stat.done;
	assign finish     = digit_done &&
	                    ((div_quo == '0) || (count_q == CNT_W'(VALUE_WIDTH - 1)));
	assign out_free   = !out_valid_q || dout.ready;
	assign rd_issue   = (state_q == ST_OUT) && out_free && !rd_pend_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (din.valid)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (finish)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (rd_issue && rd_ptr_q == '0)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		din.ready      = 1'b0;
		div_ctrl.start = 1'b0;
		div_dividend   = div_quo;
		case (state_q)
			ST_IDLE: begin
				din.ready      = 1'b1;
				div_ctrl.start = din.valid;
				div_dividend   = din.value;
			end
			ST_DIV: begin
				div_ctrl.start = digit_done && !finish;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_ptr_q    <= '0;
			rd_pend_q   <= 1'b0;
			rd_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_pend_q <= rd_issue;
			if (accept)
				count_q <= '0;
			else if (digit_done)
				count_q <= count_q + 1'b1;
			if (finish)
				rd_ptr_q <= count_q[AW-1:0];
			else if (rd_issue)
				rd_ptr_q <= rd_ptr_q - 1'b1;
			if (rd_issue)
				rd_last_q <= (rd_ptr_q == '0);
			if (rd_pend_q)
				out_valid_q <= 1'b1;
			else if (dout.ready)
				out_valid_q <= 1'b0;
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			digit_char_q <= digit_to_ascii(ram_rdata);
			last_q       <= rd_last_q;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.digit_char = digit_char_q;
	assign dout.last       = last_q;

	itoa_div #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (div_dividend),
		.radix    (radix_eff),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// digit store, least significant digit at address zero
	itoa_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_WIDTH)
	) u_store (
		.clk  (clk),
		.we   (digit_done),
		.waddr(count_q[AW-1:0]),
		.wdata(div_rem),
		.re   (rd_issue),
		.raddr(rd_ptr_q),
		.rdata(ram_rdata)
	);

`ifndef SYNTHESIS
	// store data only lands in an empty output register
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_q |-> !out_valid_q)
		else $error("store read returned while output register full");

	// divider runs and finishes only during the division phase
	a_div_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(div_stat.busy || div_stat.done) |-> state_q == ST_DIV)
		else $error("divider active outside division phase");

	// digit count never exceeds the store depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(VALUE_WIDTH))
		else $error("digit count beyond store depth");

	// finishing a number always sets the read pointer to its top digit
	a_ptr_load: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rd_ptr_q == $past(count_q[AW-1:0]))
		else $error("read pointer not loaded with top digit");
`endif

endmodule

// ===== dv/tb_integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps
// tb_integer_to_radix_ascii: self-checking testbench for the integer to radix ASCII converter.
// Predicts the digit characters of each value and checks every output transaction against them.
// Depends on itoa_pkg, itoa_ifs and integer_to_radix_ascii.
module tb_integer_to_radix_ascii;
	import itoa_pkg::*;

	localparam int VW = 64;
	localparam logic [63:0] VAL_MASK = (VW >= 64) ? '1 : ((64'd1 << VW) - 64'd1);
	// idle limit: a whole conversion passes without any transaction
	localparam int IDLE_LIMIT = 20000;
	localparam int RAND_PER_PHASE = 15;
	localparam int N_PHASES = 10;

	typedef struct {
		logic [63:0] value;
		bit          hold;   // wait until all characters have arrived before sending
	} conv_req_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} char_t;

	logic clk;
	logic arst_n;

	itoa_val_if #(.VALUE_WIDTH(VW)) din_if();
	itoa_chr_if dout_if();
	itoa_cfg_if cfg_if();

	integer_to_radix_ascii #(.VALUE_WIDTH(VW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	conv_req_t          req_q[$];
	char_t              char_q[$];
	int                 chars_pending;
	logic [RADIX_W-1:0] radix_shadow;
	int                 send_idle_pct;
	int                 recv_stall_pct;
	int                 err_count = 0;
	int                 idle_cycles = 0;

	logic [63:0] directed_vals [14] = '{
		64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
		64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
		64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
		64'd10000000000000000000, 64'd9999999999999999999, 64'd12345678901234567890
	};

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// expected characters of one value, most significant first
	function automatic void predict_digits(input logic [63:0] v, input logic [RADIX_W-1:0] r);
		logic [63:0]        base;
		logic [63:0]        rest;
		logic [DIGIT_W-1:0] digs [64];
		int                 n;
		int                 k;
		char_t              c;
		base = (r < RADIX_MIN) ? 64'(RADIX_MIN) : (r > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(r);
		rest = v & VAL_MASK;
		n = 0;
		do begin
			digs[n] = DIGIT_W'(rest % base);
			n++;
			rest = rest / base;
		end while (rest != 0 && n < 64);
		for (k = n - 1; k >= 0; k--) begin
			c.ch   = (digs[k] < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(digs[k])
			                               : ASCII_ALPHA + CHAR_W'(digs[k]);
			c.last = (k == 0);
			char_q.push_back(c);
		end
	endfunction

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int          w;
		w = $urandom_range(64, 1);
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = 64'd1 << $urandom_range(63);
			1: v = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
			2, 3: ;
			default: if (w < 64) v = v & ((64'd1 << w) - 64'd1);
		endcase
		return v;
	endfunction

	function automatic void queue_item(input logic [63:0] v, input bit hold);
		conv_req_t req;
		req.value = v;
		req.hold  = hold;
		req_q.push_back(req);
	endfunction

	// all queued values sent and every character received
	task automatic wait_drained();
		@(negedge clk);
		while (req_q.size() != 0 || din_if.valid || chars_pending != 0)
			@(negedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		wait_drained();
		// let the output stage settle before touching the radix
		repeat (8) @(negedge clk);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.radix <= r;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// value driver and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			din_if.valid  <= 1'b0;
			din_if.value  <= '0;
			dout_if.ready <= 1'b0;
		end else begin
			dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			if (!din_if.valid || din_if.ready) begin
				if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct &&
				    !(req_q[0].hold && (din_if.valid || chars_pending != 0))) begin
					din_if.valid <= 1'b1;
					din_if.value <= req_q[0].value[VW-1:0];
					void'(req_q.pop_front());
				end else begin
					din_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: radix shadow, prediction on input, checking on output
	always @(posedge clk or negedge arst_n) begin
		char_t got;
		char_t want;
		if (!arst_n) begin
			radix_shadow = RADIX_RESET;
			char_q.delete();
			chars_pending <= 0;
		end else begin
			if (cfg_if.valid && cfg_if.ready)
				radix_shadow = cfg_if.radix;
			if (dout_if.valid && dout_if.ready) begin
				got.ch   = dout_if.digit_char;
				got.last = dout_if.last;
				if (char_q.size() == 0) begin
					$error("unexpected character: digit_char %0d last %0d", got.ch, got.last);
					err_count++;
				end else begin
					want = char_q.pop_front();
					if (got.ch !== want.ch) begin
						$error("digit_char: expected %0d, got %0d", want.ch, got.ch);
						err_count++;
					end
					if (got.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, got.last);
						err_count++;
					end
				end
			end
			if (din_if.valid && din_if.ready)
				predict_digits(64'(din_if.value), radix_shadow);
			chars_pending <= char_q.size();
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			if ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
			    (cfg_if.valid && cfg_if.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// stimulus: directed values at the reset radix, then one phase per radix setting
	initial begin : stimulus
		logic [RADIX_W-1:0] radix_plan [N_PHASES];
		logic [63:0]        eff;
		int                 p;
		int                 i;
		radix_plan = '{6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd37, 6'd63, 6'd8, 6'd10, 6'd0};
		radix_plan[N_PHASES-1] = RADIX_W'($urandom_range(63));
		send_idle_pct  = 20;
		recv_stall_pct = 46;
		arst_n         = 1'b0;
		cfg_if.valid   = 1'b0;
		cfg_if.radix   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_vals[j])
			queue_item(directed_vals[j], j == 7);

		for (p = 0; p < N_PHASES; p++) begin
			write_radix(radix_plan[p]);
			send_idle_pct  = (p < 3) ? 20 : (p < 6) ? 46 : 0;
			recv_stall_pct = (p < 3) ? 46 : (p < 6) ? 20 : 0;
			eff = (radix_plan[p] < RADIX_MIN) ? 64'(RADIX_MIN) :
			      (radix_plan[p] > RADIX_MAX) ? 64'(RADIX_MAX) : 64'(radix_plan[p]);
			// zero, full range, top single digit, first two-digit and top two-digit values
			queue_item(64'd0, 1'b0);
			queue_item('1, 1'b0);
			queue_item(eff - 64'd1, 1'b0);
			queue_item(eff, 1'b0);
			queue_item(eff * eff - 64'd1, 1'b0);
			for (i = 0; i < RAND_PER_PHASE; i++)
				queue_item(rand_value(), i == 4 || $urandom_range(11) == 0);
		end

		wait_drained();
		// hold-off for stray characters
		repeat (300) @(negedge clk);
		if (err_count == 0 && char_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/itoa_pkg.sv
sv/itoa_ifs.sv
sv/itoa_ram.sv
sv/itoa_div.sv
sv/integer_to_radix_ascii.sv
dv/tb_integer_to_radix_ascii.sv
